FILE: rtl/dncd_pkg.sv
// ----------------------------------------------------------------------------
// Day number to calendar date: shared package
// Calendar constants, reciprocals for division by constants, month tables
// and the types that pass between the queue and the pipeline modules.
// ----------------------------------------------------------------------------
package dncd_pkg;

    localparam longint unsigned L_DAYS_4Y    = 64'(365 * 4 + 1);
    localparam longint unsigned L_DAYS_100Y  = L_DAYS_4Y * 64'd25 - 64'd1;
    localparam longint unsigned L_DAYS_400Y  = L_DAYS_100Y * 64'd4 + 64'd1;
    localparam longint unsigned L_DAYS_LEAP  = 64'd366;
    localparam longint unsigned L_DAYS_YEAR  = 64'd365;
    localparam longint unsigned REFORM_DAY   = 64'd2299161;
    localparam longint unsigned MARCH_ZERO_OFFSET = 64'd1721120;
    localparam longint unsigned FIRST_BC_YEAR = 64'd4713;
    localparam longint unsigned EPOCH_OFFSET  = 64'd4712;

    localparam int unsigned REM_W  = 18;
    localparam int unsigned JR_W   = 22;
    localparam int unsigned Q4_W   = 11;
    localparam int unsigned YJ_W   = Q4_W + 2;
    localparam int unsigned YOE_W  = 9;
    localparam int unsigned DOY_W  = 9;
    localparam int unsigned A1_W   = 7;
    localparam int unsigned A2_W   = 3;
    localparam int unsigned YEAR_W = 32;
    localparam int unsigned MONTHS = 12;

    localparam int unsigned RCP_W  = 19;
    localparam int unsigned RCP4_W = 23;

    localparam int unsigned SH_1460 = 29;
    localparam int unsigned SH_100Y = 34;
    localparam int unsigned SH_YEAR = 27;
    localparam int unsigned SH_4Y   = 33;

    localparam logic [RCP_W-1:0] RCP_1460 = RCP_W'(((64'd1 << SH_1460)
        + L_DAYS_4Y - 64'd2) / (L_DAYS_4Y - 64'd1));
    localparam logic [RCP_W-1:0] RCP_100Y = RCP_W'(((64'd1 << SH_100Y)
        + L_DAYS_100Y - 64'd1) / L_DAYS_100Y);
    localparam logic [RCP_W-1:0] RCP_YEAR = RCP_W'(((64'd1 << SH_YEAR)
        + L_DAYS_YEAR - 64'd1) / L_DAYS_YEAR);
    localparam logic [RCP4_W-1:0] RCP_4Y = RCP4_W'(((64'd1 << SH_4Y)
        + L_DAYS_4Y - 64'd1) / L_DAYS_4Y);

    localparam int unsigned DIG_W    = 12;
    localparam int unsigned DIGX_W   = REM_W + DIG_W;
    localparam int unsigned RCP400_W = 31;
    localparam int unsigned PQ_W     = DIGX_W + RCP400_W;
    localparam int unsigned SH_400Y  = 48;

    localparam logic [RCP400_W-1:0] RCP_400Y = RCP400_W'(((64'd1 << SH_400Y)
        + L_DAYS_400Y - 64'd1) / L_DAYS_400Y);

    localparam logic [DOY_W-1:0] MAR_START [MONTHS] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };
    localparam logic [DOY_W-1:0] JAN_START [MONTHS] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    localparam int unsigned Q_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [4:0]        day_of_month;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
        logic              before_christ;
    } t_result;

endpackage

FILE: rtl/dncd_fifo.sv
// ----------------------------------------------------------------------------
// Day number to calendar date: request queue
// Small first-in first-out queue with full and empty status.
// ----------------------------------------------------------------------------
module dncd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output dncd_pkg::t_q_status  o_status
);
    import dncd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr;
    logic             rd;

    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign wr = i_push && !o_status.full;
    assign rd = i_pop && !o_status.empty;
    assign o_data = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        unique case ({wr, rd})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> !o_status.empty)
        else $error("queue empty after a lone push");
    a_last_pop_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd && !wr && r_cnt == CNT_W'(1)) |=> o_status.empty)
        else $error("queue not empty after popping its last request");
`endif

endmodule

FILE: rtl/dncd_front.sv
// ----------------------------------------------------------------------------
// Day number to calendar date: front end
// Accepts day numbers, classifies them as Julian or Gregorian and rebases
// Gregorian days to 1 March of year zero before queueing them.
// ----------------------------------------------------------------------------
module dncd_front #(
    parameter int unsigned DAY_WIDTH = 40
) (
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [DAY_WIDTH-1:0] i_day_number,
    input  dncd_pkg::t_q_status  i_mid_status,
    output logic                 o_mid_push,
    output logic [DAY_WIDTH:0]   o_mid_data
);
    import dncd_pkg::*;

    logic is_julian;

    assign is_julian  = (i_day_number < DAY_WIDTH'(REFORM_DAY));
    assign o_full     = i_mid_status.full;
    assign o_mid_push = i_push && !i_mid_status.full;
    assign o_mid_data = {is_julian, is_julian ? i_day_number
                                              : i_day_number - DAY_WIDTH'(MARCH_ZERO_OFFSET)};

endmodule

FILE: rtl/dncd_back.sv
// ----------------------------------------------------------------------------
// Day number to calendar date: back end
// Pipelined era split by long division in twelve-bit digits, each digit a
// reciprocal multiply stage and a remainder stage, then year, day of year
// and month split for both calendars, stalling on a full result queue.
// ----------------------------------------------------------------------------
module dncd_back #(
    parameter int unsigned DAY_WIDTH = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_mid_empty,
    input  logic [DAY_WIDTH:0]   i_mid_data,
    output logic                 o_mid_pop,
    input  logic                 i_out_full,
    output logic                 o_out_push,
    output dncd_pkg::t_result    o_res
);
    import dncd_pkg::*;

    localparam int unsigned W     = DAY_WIDTH;
    localparam int unsigned N_DIG = (W + DIG_W - 1) / DIG_W;
    localparam int unsigned PW    = N_DIG * DIG_W;
    localparam int unsigned N_ST  = 2 * N_DIG;
    localparam int unsigned PR_W  = RCP_W + REM_W;
    localparam int unsigned PJ_W  = RCP4_W + JR_W;

    function automatic logic [DIG_W-1:0] dig_quot(input logic [DIGX_W-1:0] x);
        logic [PQ_W-1:0] p;
        p = PQ_W'(x) * PQ_W'(RCP_400Y);
        return p[SH_400Y +: DIG_W];
    endfunction

    function automatic logic [REM_W-1:0] dig_rem(input logic [DIGX_W-1:0] x,
                                                 input logic [DIG_W-1:0] q);
        logic [DIGX_W-1:0] qd;
        qd = DIGX_W'(q) * DIGX_W'(L_DAYS_400Y);
        return REM_W'(x - qd);
    endfunction

    logic             adv;

    logic [REM_W-1:0]  a_rm [N_DIG];
    logic [PW-1:0]     a_dq [N_DIG];
    logic [DIGX_W-1:0] a_x  [N_DIG];
    logic [DIG_W-1:0]  a_q  [N_DIG];

    logic [DIGX_W-1:0] r_ax  [N_DIG];
    logic [DIG_W-1:0]  r_aq  [N_DIG];
    logic [PW-1:0]     r_adq [N_DIG];
    logic [REM_W-1:0]  r_brm [N_DIG];
    logic [PW-1:0]     r_bdq [N_DIG];
    logic [JR_W-1:0]   r_jr [N_ST];
    logic              r_jl [N_ST];
    logic              r_dv [N_ST];

    logic              r1_vld, r1_jl, r1_a3;
    logic [REM_W-1:0]  r1_doe;
    logic [A1_W-1:0]   r1_a1;
    logic [A2_W-1:0]   r1_a2;
    logic [YEAR_W-1:0] r1_e400;
    logic [JR_W-1:0]   r1_jr;
    logic [Q4_W-1:0]   r1_q4;

    logic              r2_vld, r2_jl;
    logic [REM_W-1:0]  r2_doe;
    logic [YOE_W-1:0]  r2_yoe;
    logic [YEAR_W-1:0] r2_e400;
    logic [Q4_W-1:0]   r2_q4;
    logic [Q4_W-1:0]   r2_jrem;

    logic              r3_vld, r3_jl, r3_leap, r3_bc;
    logic [DOY_W-1:0]  r3_doy;
    logic [YOE_W-1:0]  r3_yoe;
    logic [YEAR_W-1:0] r3_e400;
    logic [YJ_W-1:0]   r3_jy;

    logic [PR_W-1:0]   p_a1, p_a2, p_yoe;
    logic [PJ_W-1:0]   p_q4;
    logic [31:0]       era32;
    logic [YEAR_W-1:0] e400;
    logic [REM_W-1:0]  gt;
    logic [JR_W-1:0]   jprod;
    logic [1:0]        c100;
    logic [REM_W-1:0]  gsub;
    logic [DOY_W-1:0]  gdoy;
    logic [Q4_W-1:0]   jr1;
    logic [1:0]        jk;
    logic [DOY_W-1:0]  jdoy;
    logic              jleap;
    logic [YJ_W-1:0]   yi;
    logic [YJ_W-1:0]   jy;
    logic              jbc;

    logic [3:0]        mp;
    logic [3:0]        jx;
    logic [3:0]        gm;
    logic [DOY_W-1:0]  jst;
    logic [DOY_W-1:0]  jbase;
    logic [DOY_W-1:0]  gd;
    logic [DOY_W-1:0]  jd;
    logic [YEAR_W-1:0] gy;

    assign adv        = !r3_vld || !i_out_full;
    assign o_mid_pop  = adv && !i_mid_empty;
    assign o_out_push = r3_vld && !i_out_full;

    // division digits: quotient is the era, remainder the day of era
    always_comb begin
        a_rm[0] = '0;
        a_dq[0] = PW'(i_mid_data[W-1:0]);
        for (int k = 1; k < N_DIG; k++) begin
            a_rm[k] = r_brm[k-1];
            a_dq[k] = r_bdq[k-1];
        end
        for (int k = 0; k < N_DIG; k++) begin
            a_x[k] = {a_rm[k], a_dq[k][PW-1 -: DIG_W]};
            a_q[k] = dig_quot(a_x[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_ST; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_dv[0] <= !i_mid_empty;
            for (int k = 1; k < N_ST; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < N_DIG; k++) begin
                r_ax[k]  <= a_x[k];
                r_aq[k]  <= a_q[k];
                r_adq[k] <= {a_dq[k][PW-DIG_W-1:0], a_q[k]};
                r_brm[k] <= dig_rem(r_ax[k], r_aq[k]);
                r_bdq[k] <= r_adq[k];
            end
            r_jr[0] <= i_mid_data[JR_W-1:0];
            r_jl[0] <= i_mid_data[W];
            for (int k = 1; k < N_ST; k++) begin
                r_jr[k] <= r_jr[k-1];
                r_jl[k] <= r_jl[k-1];
            end
        end
    end

    // stage 1: reciprocal divisions of the day of era and Julian day
    always_comb begin
        era32 = r_bdq[N_DIG-1][31:0];
        e400  = (era32 << 8) + (era32 << 7) + (era32 << 4);
        p_a1  = PR_W'(r_brm[N_DIG-1]) * PR_W'(RCP_1460);
        p_a2  = PR_W'(r_brm[N_DIG-1]) * PR_W'(RCP_100Y);
        p_q4  = PJ_W'(r_jr[N_ST-1]) * PJ_W'(RCP_4Y);
    end

    // stage 2: year of era and remainder within the four-year cycle
    always_comb begin
        gt    = r1_doe - REM_W'(r1_a1) + REM_W'(r1_a2) - REM_W'(r1_a3);
        p_yoe = PR_W'(gt) * PR_W'(RCP_YEAR);
        jprod = JR_W'(r1_q4) * JR_W'(L_DAYS_4Y);
    end

    // stage 3: day of year for both calendars, Julian year and era
    always_comb begin
        priority if (r2_yoe >= YOE_W'(300)) begin
            c100 = 2'd3;
        end else if (r2_yoe >= YOE_W'(200)) begin
            c100 = 2'd2;
        end else if (r2_yoe >= YOE_W'(100)) begin
            c100 = 2'd1;
        end else begin
            c100 = 2'd0;
        end
        gsub = REM_W'(r2_yoe) * REM_W'(L_DAYS_YEAR) + REM_W'(r2_yoe >> 2) - REM_W'(c100);
        gdoy = DOY_W'(r2_doe - gsub);

        jr1 = r2_jrem - Q4_W'(L_DAYS_LEAP);
        priority if (r2_jrem < Q4_W'(L_DAYS_LEAP)) begin
            jk = 2'd0;  jdoy = DOY_W'(r2_jrem);  jleap = 1'b1;
        end else if (jr1 < Q4_W'(L_DAYS_YEAR)) begin
            jk = 2'd1;  jdoy = DOY_W'(jr1);  jleap = 1'b0;
        end else if (jr1 < Q4_W'(2 * L_DAYS_YEAR)) begin
            jk = 2'd2;  jdoy = DOY_W'(jr1 - Q4_W'(L_DAYS_YEAR));  jleap = 1'b0;
        end else begin
            jk = 2'd3;  jdoy = DOY_W'(jr1 - Q4_W'(2 * L_DAYS_YEAR));  jleap = 1'b0;
        end
        yi = {r2_q4, 2'b00} + YJ_W'(jk);
        if (yi < YJ_W'(FIRST_BC_YEAR)) begin
            jy  = YJ_W'(FIRST_BC_YEAR) - yi;
            jbc = 1'b1;
        end else begin
            jy  = yi - YJ_W'(EPOCH_OFFSET);
            jbc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= r_dv[N_ST-1];
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_jl   <= r_jl[N_ST-1];
            r1_doe  <= r_brm[N_DIG-1];
            r1_a1   <= p_a1[SH_1460 +: A1_W];
            r1_a2   <= p_a2[SH_100Y +: A2_W];
            r1_a3   <= (r_brm[N_DIG-1] == REM_W'(L_DAYS_400Y - 64'd1));
            r1_e400 <= e400;
            r1_jr   <= r_jr[N_ST-1];
            r1_q4   <= p_q4[SH_4Y +: Q4_W];

            r2_jl   <= r1_jl;
            r2_doe  <= r1_doe;
            r2_yoe  <= p_yoe[SH_YEAR +: YOE_W];
            r2_e400 <= r1_e400;
            r2_q4   <= r1_q4;
            r2_jrem <= Q4_W'(r1_jr - jprod);

            r3_jl   <= r2_jl;
            r3_doy  <= r2_jl ? jdoy : gdoy;
            r3_leap <= jleap;
            r3_yoe  <= r2_yoe;
            r3_e400 <= r2_e400;
            r3_jy   <= jy;
            r3_bc   <= jbc;
        end
    end

    // month split from the tables of month starts
    always_comb begin
        mp = 4'd0;
        jx = 4'd0;
        for (int i = 1; i < MONTHS; i++) begin
            jst = JAN_START[i] + {{(DOY_W - 1){1'b0}}, r3_leap && (i >= 2)};
            if (r3_doy >= MAR_START[i]) begin
                mp = 4'(i);
            end
            if (r3_doy >= jst) begin
                jx = 4'(i);
            end
        end
        jbase = JAN_START[jx] + {{(DOY_W - 1){1'b0}}, r3_leap && (jx >= 4'd2)};
        gd    = r3_doy - MAR_START[mp] + 1'b1;
        jd    = r3_doy - jbase + 1'b1;
        gm    = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        gy    = r3_e400 + YEAR_W'(r3_yoe) + YEAR_W'(mp >= 4'd10);

        if (r3_jl) begin
            o_res.day_of_month = 5'(jd);
            o_res.month        = jx + 4'd1;
            o_res.year         = YEAR_W'(r3_jy);
            o_res.before_christ = r3_bc;
        end else begin
            o_res.day_of_month = 5'(gd);
            o_res.month        = gm;
            o_res.year         = gy;
            o_res.before_christ = 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_doe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[N_ST-1] |-> (r_brm[N_DIG-1] < REM_W'(L_DAYS_400Y)))
        else $error("day of era out of range");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_vld && i_out_full) |=> (r3_vld && $stable(r3_doy) && $stable(r3_jy)))
        else $error("last stage changed while the result queue was full");
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (o_res.month >= 4'd1 && o_res.month <= 4'd12
                        && o_res.day_of_month != 5'd0))
        else $error("result date out of range");
`endif

endmodule

FILE: rtl/day_number_to_calendar_date_top.sv
// ----------------------------------------------------------------------------
// Day number to calendar date: top level
// Path from accepted request to result: the request queue, then a reciprocal multiply stage
// and a remainder stage per 12-bit division digit, then three calendar stages.
// Throughput: one request per cycle; a full result queue stalls the pipeline.
// Reset: synchronous, active low; clears queues and stage valid bits at once.
// ----------------------------------------------------------------------------
module day_number_to_calendar_date_top #(
    parameter int unsigned DAY_WIDTH = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [DAY_WIDTH-1:0] i_day_number,
    output logic                 empty,
    input  logic                 pop,
    output logic [4:0]           o_day_of_month,
    output logic [3:0]           o_month,
    output logic [31:0]          o_year,
    output logic                 o_before_christ
);
    import dncd_pkg::*;

    t_q_status            mid_status;
    t_q_status            out_status;
    logic                 mid_push;
    logic                 mid_pop;
    logic [DAY_WIDTH:0]   mid_wdata;
    logic [DAY_WIDTH:0]   mid_rdata;
    logic                 out_push;
    t_result              back_res;
    logic [$bits(t_result)-1:0] out_rdata;
    t_result              res;

    dncd_front #(.DAY_WIDTH(DAY_WIDTH)) u_front (
        .i_push       (push),
        .o_full       (full),
        .i_day_number (i_day_number),
        .i_mid_status (mid_status),
        .o_mid_push   (mid_push),
        .o_mid_data   (mid_wdata)
    );

    dncd_fifo #(.WIDTH(DAY_WIDTH + 1), .DEPTH(Q_DEPTH)) u_mid_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (mid_push),
        .i_data   (mid_wdata),
        .i_pop    (mid_pop),
        .o_data   (mid_rdata),
        .o_status (mid_status)
    );

    dncd_back #(.DAY_WIDTH(DAY_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_status.empty),
        .i_mid_data  (mid_rdata),
        .o_mid_pop   (mid_pop),
        .i_out_full  (out_status.full),
        .o_out_push  (out_push),
        .o_res       (back_res)
    );

    dncd_fifo #(.WIDTH($bits(t_result)), .DEPTH(Q_DEPTH)) u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (out_push),
        .i_data   (back_res),
        .i_pop    (pop),
        .o_data   (out_rdata),
        .o_status (out_status)
    );

    assign res             = out_rdata;
    assign empty           = out_status.empty;
    assign o_day_of_month  = res.day_of_month;
    assign o_month         = res.month;
    assign o_year          = res.year;
    assign o_before_christ = res.before_christ;

endmodule
